### rtl/core/tkne_pkg.sv
`default_nettype none

package tkne_pkg;

    // default sizing of the sensor array
    localparam int KEYS_PER_DEVICE_DEF = 6;
    localparam int DEVICE_COUNT_DEF    = 2;

    // widest switch word a device can deliver
    localparam int SWITCH_W = 16;

    // event constants
    localparam logic [6:0] VEL_ON  = 7'h7f;
    localparam logic [6:0] VEL_OFF = 7'h40;

    // register index of the octave offset
    localparam logic REG_OCTAVE = 1'b0;

    typedef struct packed {
        logic [1:0]          device_index;
        logic                read_error;
        logic [SWITCH_W-1:0] switch_bits;
    } scan_item_t;

    typedef struct packed {
        logic [6:0] note_number;
        logic       note_on;
        logic [6:0] velocity;
        logic [3:0] key_number;
        logic       last_event;
    } note_item_t;

    // work handed from the front end to the sequencer
    typedef struct packed {
        logic                go;
        logic [SWITCH_W-1:0] changed;
        logic [SWITCH_W-1:0] press;
        logic [5:0]          base_key;
        logic [7:0]          oct_offset;
    } scan_start_t;

    // operands of the shared note adder
    typedef struct packed {
        logic [5:0] base_key;
        logic [7:0] oct_offset;
        logic [3:0] key_idx;
    } alu_op_t;

    typedef struct packed {
        logic [5:0] key_sum;
        logic [7:0] note_sum;
    } alu_res_t;

endpackage

`default_nettype wire

### rtl/core/touch_key_change_to_note_events.sv
// touch key change to note events
//
// scan channel (scan_valid / scan_ready / scan): one item per sensor read,
// carrying the device index, a read-error flag and the device switch word.
// note channel (note_valid / note_ready / note): one item per changed key,
// lowest key first; the final item of a scan has last_event set.
// apb port: one register, the octave offset at address 0 (bits 3:0),
// readable; pready is tied high.
//
// a taken scan is first registered into the sequencer; as the walk reaches
// each changed key, its note item is registered in the output register.
// throughput: the sequencer walks one key position per cycle through the
// shared note adder, while note_ready does not stall it, up to the highest
// changed key, so a scan holds the block until its walk ends; scans with
// no change, a read error or an unknown device release it the next cycle.
// a stalled note_ready freezes the walk on the next changed key while the
// output register holds its item; scan_ready stays low until the walk ends.
// reset clears every stored switch word (no key touched), the octave and
// all handshake state; the block is ready in the first cycle after reset.

`default_nettype none

module touch_key_change_to_note_events #(
    parameter int KEYS_PER_DEVICE = tkne_pkg::KEYS_PER_DEVICE_DEF,
    parameter int DEVICE_COUNT    = tkne_pkg::DEVICE_COUNT_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    // scan items in
    input  wire                  scan_valid,
    output logic                 scan_ready,
    input  tkne_pkg::scan_item_t scan,
    // note items out
    output logic                 note_valid,
    input  wire                  note_ready,
    output tkne_pkg::note_item_t note,
    // configuration
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [2:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import tkne_pkg::*;

    localparam int DEV_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;

    // stored switch word per device, low key bits only
    logic [KEYS_PER_DEVICE-1:0] prev_reg [DEVICE_COUNT];
    logic [3:0]                 octave_reg;

    logic                       scan_take;
    logic                       dev_ok;
    logic                       use_scan;
    logic [DEV_W-1:0]           dev_sel;
    logic [KEYS_PER_DEVICE-1:0] sw_keys;
    logic [KEYS_PER_DEVICE-1:0] diff;
    logic                       cfg_write;
    logic                       seq_idle;

    scan_start_t start;
    alu_op_t     alu_op;
    alu_res_t    alu_res;

    // apb: zero wait state, octave register at index 0
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_OCTAVE) ? {28'd0, octave_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_reg <= '0;
        end
        else if (cfg_write && (paddr[2] == REG_OCTAVE))
        begin
            octave_reg <= pwdata[3:0];
        end
    end

    // accept a scan only while the sequencer is parked
    assign scan_ready = seq_idle;
    assign scan_take  = scan_valid && scan_ready;

    // error scans and unknown devices are dropped without touching state
    assign dev_ok   = (3'(scan.device_index) < 3'(DEVICE_COUNT));
    assign use_scan = scan_take && dev_ok && !scan.read_error;
    assign dev_sel  = DEV_W'(scan.device_index);
    assign sw_keys  = scan.switch_bits[KEYS_PER_DEVICE-1:0];
    assign diff     = prev_reg[dev_sel] ^ sw_keys;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < DEVICE_COUNT; d++)
            begin
                prev_reg[d] <= '0;
            end
        end
        else if (use_scan)
        begin
            prev_reg[dev_sel] <= sw_keys;
        end
    end

    // start the walk: changed keys, press bits, device base and octave offset
    assign start.go         = use_scan;
    assign start.changed    = SWITCH_W'(diff);
    assign start.press      = SWITCH_W'(sw_keys);
    assign start.base_key   = 6'(scan.device_index) * 6'(KEYS_PER_DEVICE);
    assign start.oct_offset = 8'({octave_reg, 3'b000}) + 8'({octave_reg, 2'b00});

    tkne_note_alu u_alu (
        .op  (alu_op),
        .res (alu_res)
    );

    tkne_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .idle       (seq_idle),
        .op         (alu_op),
        .res        (alu_res),
        .note_valid (note_valid),
        .note_ready (note_ready),
        .note       (note)
    );

endmodule

`default_nettype wire

### rtl/core/tkne_note_alu.sv
`default_nettype none

module tkne_note_alu (
    input  tkne_pkg::alu_op_t  op,
    output tkne_pkg::alu_res_t res
);
    import tkne_pkg::*;

    logic [5:0] key_sum;

    // key = device base + key index, note = key + octave offset
    assign key_sum      = op.base_key + 6'(op.key_idx);
    assign res.key_sum  = key_sum;
    assign res.note_sum = 8'(key_sum) + op.oct_offset;

endmodule

`default_nettype wire

### rtl/core/tkne_seq.sv
`default_nettype none

module tkne_seq (
    input  wire                   clk,
    input  wire                   rst_n,
    input  tkne_pkg::scan_start_t start,
    output logic                  idle,
    output tkne_pkg::alu_op_t     op,
    input  tkne_pkg::alu_res_t    res,
    output logic                  note_valid,
    input  wire                   note_ready,
    output tkne_pkg::note_item_t  note
);
    import tkne_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                state_reg, state_next;
    logic [SWITCH_W-1:0] chg_reg, chg_next;
    logic [SWITCH_W-1:0] press_reg, press_next;
    logic [3:0]          idx_reg, idx_next;
    logic [5:0]          base_reg, base_next;
    logic [7:0]          oct_reg, oct_next;
    logic                out_valid_reg, out_valid_next;
    note_item_t          out_reg, out_next;

    logic slot_free;
    logic load;
    logic advance;
    logic press_now;

    assign idle        = (state_reg == ST_IDLE);
    assign op.base_key = base_reg;
    assign op.oct_offset = oct_reg;
    assign op.key_idx  = idx_reg;
    assign note_valid  = out_valid_reg;
    assign note        = out_reg;

    assign slot_free = !out_valid_reg || note_ready;
    assign press_now = press_reg[0];
    assign load      = (state_reg == ST_SCAN) && chg_reg[0] && slot_free;
    assign advance   = (state_reg == ST_SCAN) && (!chg_reg[0] || slot_free);

    always_comb
    begin
        state_next     = state_reg;
        chg_next       = chg_reg;
        press_next     = press_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        oct_next       = oct_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !note_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start.go)
                begin
                    chg_next   = start.changed;
                    press_next = start.press;
                    idx_next   = '0;
                    base_next  = start.base_key;
                    oct_next   = start.oct_offset;
                    if (start.changed != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    chg_next   = chg_reg >> 1;
                    press_next = press_reg >> 1;
                    idx_next   = idx_reg + 4'd1;
                    if ((chg_reg >> 1) == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next       = 1'b1;
            out_next.note_number = res.note_sum[6:0];
            out_next.note_on     = press_now;
            out_next.velocity    = press_now ? VEL_ON : VEL_OFF;
            out_next.key_number  = res.key_sum[3:0];
            // no changed key above this one
            out_next.last_event  = (chg_reg[SWITCH_W-1:1] == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chg_reg       <= chg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        press_reg <= press_next;
        idx_reg   <= idx_next;
        base_reg  <= base_next;
        oct_reg   <= oct_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

### rtl/core/tkne_checker.sv
`default_nettype none

module tkne_checker (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  scan_valid,
    input wire                  scan_ready,
    input tkne_pkg::scan_item_t scan,
    input wire                  note_valid,
    input wire                  note_ready,
    input tkne_pkg::note_item_t note
);
    import tkne_pkg::*;

    // a held note item keeps its payload
    a_note_hold: assert property (@(posedge clk) disable iff (!rst_n)
        note_valid && !note_ready |=> note_valid && $stable(note))
        else $error("note item changed while stalled");

    // velocity follows the event kind
    a_velocity: assert property (@(posedge clk) disable iff (!rst_n)
        note_valid |-> (note.velocity == (note.note_on ? VEL_ON : VEL_OFF)))
        else $error("velocity does not match note_on");

    // more events pending means the scan walk is still running
    a_busy_pending: assert property (@(posedge clk) disable iff (!rst_n)
        note_valid && !note.last_event |-> !scan_ready)
        else $error("scan taken while events of the last scan pending");

    // a failed read is dropped and leaves the block ready
    a_error_drop: assert property (@(posedge clk) disable iff (!rst_n)
        scan_valid && scan_ready && scan.read_error |=> scan_ready)
        else $error("read error scan started a walk");

endmodule

bind touch_key_change_to_note_events tkne_checker u_tkne_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .scan_valid (scan_valid),
    .scan_ready (scan_ready),
    .scan       (scan),
    .note_valid (note_valid),
    .note_ready (note_ready),
    .note       (note)
);

`default_nettype wire
